@@ design/vsps_pkg.sv @@
// Shared types, constants and helper functions for the SPS header parser.
package vsps_pkg;

  localparam int MAX_GOLOMB_ZEROS_DEF = 31;
  localparam int GZ_W   = 6;
  localparam int ACC_W  = 33;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_ID    = 2'd2;

  typedef enum logic [4:0] {
    PH_VPS, PH_MAXSUB, PH_NEST, PH_SKIP_A, PH_SKIP_B, PH_SKIP_C, PH_SUBSKIP,
    PH_SPSID, PH_CHROMA, PH_SEPCOL, PH_WIDTH, PH_HEIGHT, PH_CONFFLAG,
    PH_CL, PH_CR, PH_CT, PH_CB, PH_LUMA, PH_CDEPTH, PH_POC, PH_ORDFLAG,
    PH_ORD0, PH_ORD1, PH_ORD2, PH_LOG2MIN, PH_LOG2DIFF, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       short_set;
  } q_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  video_set_id;
    logic [3:0]  seq_set_id;
    logic [7:0]  chroma_format;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic [15:0] crop_left;
    logic [15:0] crop_right;
    logic [15:0] crop_top;
    logic [15:0] crop_bottom;
    logic [7:0]  luma_depth_minus8;
    logic [9:0]  ctu_size_log2;
  } out_word_t;

  function automatic logic [GZ_W-1:0] fixed_width(input phase_t ph);
    logic [GZ_W-1:0] w;
    unique case (ph)
      PH_VPS:    w = GZ_W'(4);
      PH_MAXSUB: w = GZ_W'(3);
      PH_NEST, PH_SEPCOL, PH_CONFFLAG, PH_ORDFLAG: w = GZ_W'(1);
      PH_SKIP_A, PH_SKIP_B: w = GZ_W'(32);
      PH_SKIP_C, PH_SUBSKIP: w = GZ_W'(16);
      default:   w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] sat16(input logic [ACC_W-1:0] v);
    return (|v[ACC_W-1:16]) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

@@ design/vsps_front.sv @@
// Input stage: accepts payload words, counts bytes per set and tags short sets.
module vsps_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  vsps_pkg::in_word_t item,
  output logic               q_push,
  output vsps_pkg::q_word_t  q_word,
  input  logic               q_full
);

  logic [2:0] byte_count;
  logic [2:0] byte_count_next;
  logic [2:0] count_inc;

  assign item_ready = !q_full;
  assign q_push     = item_valid && item_ready;

  always_comb begin
    count_inc = (byte_count == 3'd7) ? byte_count : byte_count + 3'd1;
    byte_count_next = byte_count;
    if (q_push) begin
      byte_count_next = item.last_byte ? 3'd0 : count_inc;
    end
    q_word.data_byte = item.data_byte;
    q_word.last_byte = item.last_byte;
    q_word.short_set = item.last_byte && (count_inc < 3'd4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

endmodule

@@ design/vsps_fifo.sv @@
// Two-entry queue between the input stage and the bit-serial parser.
module vsps_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vsps_pkg::q_word_t push_word,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output vsps_pkg::q_word_t pop_word
);

  vsps_pkg::q_word_t                  entries [vsps_pkg::QDEPTH];
  logic [vsps_pkg::QPTR_W-1:0]        wr_ptr;
  logic [vsps_pkg::QPTR_W-1:0]        rd_ptr;
  logic [vsps_pkg::QCNT_W-1:0]        count;
  logic                               do_push;
  logic                               do_pop;

  assign full      = (count == vsps_pkg::QCNT_W'(vsps_pkg::QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_word  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/vsps_back.sv @@
// Bit-serial field parser with zero padding and the registered result word.
module vsps_back #(
  parameter int MAX_GOLOMB_ZEROS = vsps_pkg::MAX_GOLOMB_ZEROS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  vsps_pkg::q_word_t   q_word,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_ready,
  output vsps_pkg::out_word_t result
);

  localparam int GW = vsps_pkg::GZ_W;
  localparam int AW = vsps_pkg::ACC_W;
  localparam logic [GW-1:0] MaxZ = GW'(MAX_GOLOMB_ZEROS);

  logic       busy, busy_next;
  logic       fill, fill_next;
  logic [2:0] bit_cnt, bit_cnt_next;
  logic [7:0] shreg, shreg_next;
  logic       cur_last, cur_last_next;
  logic       cur_short, cur_short_next;

  vsps_pkg::phase_t phase, phase_next;
  logic [GW-1:0] gz, gz_next;
  logic [AW-1:0] acc, acc_next;
  logic          in_suffix, in_suffix_next;
  logic [3:0]    loop_idx, loop_idx_next;
  logic [2:0]    slc, slc_next;
  logic          id_error, id_error_next;

  logic [3:0]  f_vps, f_vps_next;
  logic [7:0]  f_sps, f_sps_next;
  logic [7:0]  f_chroma, f_chroma_next;
  logic [15:0] f_width, f_width_next;
  logic [15:0] f_height, f_height_next;
  logic [15:0] f_cl, f_cl_next;
  logic [15:0] f_cr, f_cr_next;
  logic [15:0] f_ct, f_ct_next;
  logic [15:0] f_cb, f_cb_next;
  logic [7:0]  f_luma, f_luma_next;
  logic [7:0]  f_lmin, f_lmin_next;
  logic [7:0]  f_ldiff, f_ldiff_next;

  vsps_pkg::out_word_t result_next;
  logic                result_valid_next;

  logic          feed;
  logic          fbit;
  logic          emit;
  logic          fin;
  logic [AW-1:0] fin_v;
  logic [GW-1:0] w;
  logic [GW-1:0] gz_inc;
  logic [GW-1:0] gz_dec;
  logic [AW-1:0] acc_shift;
  logic [3:0]    loop_dec;

  always_comb begin
    busy_next      = busy;
    fill_next      = fill;
    bit_cnt_next   = bit_cnt;
    shreg_next     = shreg;
    cur_last_next  = cur_last;
    cur_short_next = cur_short;
    feed           = 1'b0;
    fbit           = 1'b0;
    emit           = 1'b0;
    q_pop          = 1'b0;

    if (busy) begin
      feed         = 1'b1;
      fbit         = shreg[7];
      shreg_next   = {shreg[6:0], 1'b0};
      bit_cnt_next = bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy_next = 1'b0;
        if (cur_last) begin
          fill_next = 1'b1;
        end else begin
          q_pop = q_valid;
        end
      end
    end else if (fill) begin
      if (phase != vsps_pkg::PH_DONE) begin
        feed = 1'b1;
      end else if (!result_valid || result_ready) begin
        emit      = 1'b1;
        fill_next = 1'b0;
        q_pop     = q_valid;
      end
    end else begin
      q_pop = q_valid;
    end

    if (q_pop) begin
      busy_next      = 1'b1;
      bit_cnt_next   = '0;
      shreg_next     = q_word.data_byte;
      cur_last_next  = q_word.last_byte;
      cur_short_next = q_word.short_set;
    end
  end

  always_comb begin
    phase_next     = phase;
    gz_next        = gz;
    acc_next       = acc;
    in_suffix_next = in_suffix;
    loop_idx_next  = loop_idx;
    slc_next       = slc;
    id_error_next  = id_error;
    f_vps_next     = f_vps;
    f_sps_next     = f_sps;
    f_chroma_next  = f_chroma;
    f_width_next   = f_width;
    f_height_next  = f_height;
    f_cl_next      = f_cl;
    f_cr_next      = f_cr;
    f_ct_next      = f_ct;
    f_cb_next      = f_cb;
    f_luma_next    = f_luma;
    f_lmin_next    = f_lmin;
    f_ldiff_next   = f_ldiff;
    fin            = 1'b0;
    fin_v          = '0;
    w              = vsps_pkg::fixed_width(phase);
    gz_inc         = gz + GW'(1);
    gz_dec         = (gz != '0) ? gz - GW'(1) : gz;
    acc_shift      = {acc[AW-2:0], fbit};
    loop_dec       = (loop_idx != '0) ? loop_idx - 4'd1 : loop_idx;

    if (feed && phase != vsps_pkg::PH_DONE) begin
      if (w != '0) begin
        acc_next = acc_shift;
        gz_next  = gz_inc;
        if (gz_inc >= w) begin
          fin   = 1'b1;
          fin_v = acc_shift;
        end
      end else if (!in_suffix) begin
        if (fbit) begin
          in_suffix_next = 1'b1;
          acc_next       = AW'(1);
          if (gz == '0) begin
            fin = 1'b1;
          end
        end else begin
          gz_next = gz_inc;
          if (gz_inc >= MaxZ) begin
            in_suffix_next = 1'b1;
            acc_next       = AW'(1);
          end
        end
      end else begin
        acc_next = acc_shift;
        gz_next  = gz_dec;
        if (gz_dec == '0) begin
          fin   = 1'b1;
          fin_v = acc_shift - AW'(1);
        end
      end
    end

    if (fin) begin
      acc_next       = '0;
      gz_next        = '0;
      in_suffix_next = 1'b0;
      unique case (phase)
        vsps_pkg::PH_VPS: begin
          f_vps_next = fin_v[3:0];
          phase_next = vsps_pkg::PH_MAXSUB;
        end
        vsps_pkg::PH_MAXSUB: begin
          slc_next   = fin_v[2:0];
          phase_next = vsps_pkg::PH_NEST;
        end
        vsps_pkg::PH_NEST:   phase_next = vsps_pkg::PH_SKIP_A;
        vsps_pkg::PH_SKIP_A: phase_next = vsps_pkg::PH_SKIP_B;
        vsps_pkg::PH_SKIP_B: phase_next = vsps_pkg::PH_SKIP_C;
        vsps_pkg::PH_SKIP_C: begin
          phase_next = (slc != '0) ? vsps_pkg::PH_SUBSKIP : vsps_pkg::PH_SPSID;
        end
        vsps_pkg::PH_SUBSKIP: phase_next = vsps_pkg::PH_SPSID;
        vsps_pkg::PH_SPSID: begin
          f_sps_next = fin_v[7:0];
          if (fin_v[7:0] >= 8'd16) begin
            id_error_next = 1'b1;
            phase_next    = vsps_pkg::PH_DONE;
          end else begin
            phase_next = vsps_pkg::PH_CHROMA;
          end
        end
        vsps_pkg::PH_CHROMA: begin
          f_chroma_next = fin_v[7:0];
          phase_next    = (fin_v[7:0] == 8'd3) ? vsps_pkg::PH_SEPCOL : vsps_pkg::PH_WIDTH;
        end
        vsps_pkg::PH_SEPCOL: phase_next = vsps_pkg::PH_WIDTH;
        vsps_pkg::PH_WIDTH: begin
          f_width_next = vsps_pkg::sat16(fin_v);
          phase_next   = vsps_pkg::PH_HEIGHT;
        end
        vsps_pkg::PH_HEIGHT: begin
          f_height_next = vsps_pkg::sat16(fin_v);
          phase_next    = vsps_pkg::PH_CONFFLAG;
        end
        vsps_pkg::PH_CONFFLAG: begin
          phase_next = (fin_v != '0) ? vsps_pkg::PH_CL : vsps_pkg::PH_LUMA;
        end
        vsps_pkg::PH_CL: begin
          f_cl_next  = vsps_pkg::sat16(fin_v);
          phase_next = vsps_pkg::PH_CR;
        end
        vsps_pkg::PH_CR: begin
          f_cr_next  = vsps_pkg::sat16(fin_v);
          phase_next = vsps_pkg::PH_CT;
        end
        vsps_pkg::PH_CT: begin
          f_ct_next  = vsps_pkg::sat16(fin_v);
          phase_next = vsps_pkg::PH_CB;
        end
        vsps_pkg::PH_CB: begin
          f_cb_next  = vsps_pkg::sat16(fin_v);
          phase_next = vsps_pkg::PH_LUMA;
        end
        vsps_pkg::PH_LUMA: begin
          f_luma_next = fin_v[7:0];
          phase_next  = vsps_pkg::PH_CDEPTH;
        end
        vsps_pkg::PH_CDEPTH: phase_next = vsps_pkg::PH_POC;
        vsps_pkg::PH_POC:    phase_next = vsps_pkg::PH_ORDFLAG;
        vsps_pkg::PH_ORDFLAG: begin
          loop_idx_next = (fin_v != '0) ? {1'b0, slc} + 4'd1 : 4'd1;
          phase_next    = vsps_pkg::PH_ORD0;
        end
        vsps_pkg::PH_ORD0: phase_next = vsps_pkg::PH_ORD1;
        vsps_pkg::PH_ORD1: phase_next = vsps_pkg::PH_ORD2;
        vsps_pkg::PH_ORD2: begin
          loop_idx_next = loop_dec;
          phase_next    = (loop_dec != '0) ? vsps_pkg::PH_ORD0 : vsps_pkg::PH_LOG2MIN;
        end
        vsps_pkg::PH_LOG2MIN: begin
          f_lmin_next = fin_v[7:0];
          phase_next  = vsps_pkg::PH_LOG2DIFF;
        end
        vsps_pkg::PH_LOG2DIFF: begin
          f_ldiff_next = fin_v[7:0];
          phase_next   = vsps_pkg::PH_DONE;
        end
        default: phase_next = vsps_pkg::PH_DONE;
      endcase
    end

    if (emit) begin
      phase_next     = vsps_pkg::PH_VPS;
      gz_next        = '0;
      acc_next       = '0;
      in_suffix_next = 1'b0;
      loop_idx_next  = '0;
      slc_next       = '0;
      id_error_next  = 1'b0;
      f_vps_next     = '0;
      f_sps_next     = '0;
      f_chroma_next  = '0;
      f_width_next   = '0;
      f_height_next  = '0;
      f_cl_next      = '0;
      f_cr_next      = '0;
      f_ct_next      = '0;
      f_cb_next      = '0;
      f_luma_next    = '0;
      f_lmin_next    = '0;
      f_ldiff_next   = '0;
    end
  end

  always_comb begin
    result_next = '0;
    if (cur_short) begin
      result_next.status = vsps_pkg::ST_SHORT;
    end else if (id_error) begin
      result_next.status       = vsps_pkg::ST_ID;
      result_next.video_set_id = f_vps;
      result_next.seq_set_id   = f_sps[3:0];
    end else begin
      result_next.status            = vsps_pkg::ST_OK;
      result_next.video_set_id      = f_vps;
      result_next.seq_set_id        = f_sps[3:0];
      result_next.chroma_format     = f_chroma;
      result_next.pic_width         = f_width;
      result_next.pic_height        = f_height;
      result_next.crop_left         = f_cl;
      result_next.crop_right        = f_cr;
      result_next.crop_top          = f_ct;
      result_next.crop_bottom       = f_cb;
      result_next.luma_depth_minus8 = f_luma;
      result_next.ctu_size_log2     = 10'd3 + {2'b00, f_lmin} + {2'b00, f_ldiff};
    end
    result_valid_next = emit || (result_valid && !result_ready);
  end

  always_ff @(posedge clk) begin
    shreg     <= shreg_next;
    cur_last  <= cur_last_next;
    cur_short <= cur_short_next;
    if (emit) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      fill         <= 1'b0;
      bit_cnt      <= '0;
      result_valid <= 1'b0;
      phase        <= vsps_pkg::PH_VPS;
      gz           <= '0;
      acc          <= '0;
      in_suffix    <= 1'b0;
      loop_idx     <= '0;
      slc          <= '0;
      id_error     <= 1'b0;
      f_vps        <= '0;
      f_sps        <= '0;
      f_chroma     <= '0;
      f_width      <= '0;
      f_height     <= '0;
      f_cl         <= '0;
      f_cr         <= '0;
      f_ct         <= '0;
      f_cb         <= '0;
      f_luma       <= '0;
      f_lmin       <= '0;
      f_ldiff      <= '0;
    end else begin
      busy         <= busy_next;
      fill         <= fill_next;
      bit_cnt      <= bit_cnt_next;
      result_valid <= result_valid_next;
      phase        <= phase_next;
      gz           <= gz_next;
      acc          <= acc_next;
      in_suffix    <= in_suffix_next;
      loop_idx     <= loop_idx_next;
      slc          <= slc_next;
      id_error     <= id_error_next;
      f_vps        <= f_vps_next;
      f_sps        <= f_sps_next;
      f_chroma     <= f_chroma_next;
      f_width      <= f_width_next;
      f_height     <= f_height_next;
      f_cl         <= f_cl_next;
      f_cr         <= f_cr_next;
      f_ct         <= f_ct_next;
      f_cb         <= f_cb_next;
      f_luma       <= f_luma_next;
      f_lmin       <= f_lmin_next;
      f_ldiff      <= f_ldiff_next;
    end
  end

  a_emit_restarts: assert property (@(posedge clk) disable iff (rst)
    emit |=> (phase == vsps_pkg::PH_VPS) && !id_error && !fill)
    else $error("parser did not restart after result");

  a_no_pop_while_padding: assert property (@(posedge clk) disable iff (rst)
    (fill && phase != vsps_pkg::PH_DONE) |-> !q_pop)
    else $error("word taken while padding last set");

  a_id_error_done: assert property (@(posedge clk) disable iff (rst)
    id_error |-> (phase == vsps_pkg::PH_DONE))
    else $error("parsing continued after id error");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == vsps_pkg::ST_OK ||
                      result.status == vsps_pkg::ST_SHORT ||
                      result.status == vsps_pkg::ST_ID))
    else $error("illegal result status");

  a_busy_fill_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(busy && fill))
    else $error("shifting and padding at once");

endmodule

@@ design/video_sps_header_parser.sv @@
// Top level of the SPS header parser: input stage, word queue and bit-serial parser.
// Usage:
//   item channel: one payload byte per word (emulation bytes removed), MSB
//   first, with last_byte set on the final byte of a parameter set.
//   result channel: one result word per parameter set, sent after its last
//   byte; status is ok, too short (under 4 bytes) or id out of range.
// Throughput: the parser shifts one header bit per cycle, but waits whenever the
//   queue is empty; a two-word queue in front lets the input side accept ahead
//   while the parser works.
// Order: with the parser idle, a last byte passes through the queue and is
//   shifted in, then zero bits are fed to complete any unread header fields,
//   then the result register is loaded; surplus bytes past the header are
//   still shifted through in full.
// Reset: rst is synchronous; it empties the queue, drops any partial
//   parameter set and drops any pending result.
// Stall: a held result stays in the output register; the parser keeps
//   working on following bytes and waits only when it has the next result.
module video_sps_header_parser #(
  parameter int MAX_GOLOMB_ZEROS = vsps_pkg::MAX_GOLOMB_ZEROS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  vsps_pkg::in_word_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output vsps_pkg::out_word_t result
);

  logic              q_push;
  logic              q_full;
  vsps_pkg::q_word_t q_in;
  logic              q_pop;
  logic              q_valid;
  vsps_pkg::q_word_t q_out;

  vsps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_push     (q_push),
    .q_word     (q_in),
    .q_full     (q_full)
  );

  vsps_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_word  (q_out)
  );

  vsps_back #(
    .MAX_GOLOMB_ZEROS (MAX_GOLOMB_ZEROS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_word       (q_out),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
